>>> hw/rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants of the vector normaliser: default sizes, port widths and
// the fixed-point format of the unit components.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

    localparam int MAX_LEN     = 64;
    localparam int SAMPLE_BITS = 24;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_USER_W  = 2;

    localparam int USER_ZERO   = 0;
    localparam int USER_TRUNC  = 1;

    localparam int FRAC_BITS   = 30;
    localparam int QUOT_W      = FRAC_BITS + 1;

endpackage

`default_nettype wire

>>> hw/rtl/vn_store.sv
// ----------------------------------------------------------------------------
// vn_store
// Element store: simple dual-port synchronous RAM, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_store #(
    parameter int DEPTH  = vn_pkg::MAX_LEN,
    parameter int WIDTH  = vn_pkg::SAMPLE_BITS,
    parameter int ADDR_W = 6
) (
    input  wire               i_clk,
    input  wire               i_wr_en,
    input  wire  [ADDR_W-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]  i_wr_data,
    input  wire               i_rd_en,
    input  wire  [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt
// Iterative floor square root, one result bit per cycle (digit-by-digit,
// restoring form on the remainder).
// ----------------------------------------------------------------------------
`default_nettype none

module vn_sqrt #(
    parameter int SUM_W  = 53,
    parameter int ROOT_W = 27
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [SUM_W-1:0]  i_x,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int W     = SUM_W + 1;
    localparam int CNT_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_x;
    logic [W-1:0]     r_r;
    logic [W-1:0]     r_b;
    logic [W-1:0]     w_t;
    logic             w_ge;

    assign w_t  = r_r + r_b;
    assign w_ge = (r_x >= w_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= W'(i_x);
            r_r <= '0;
            r_b <= W'(1) << (2 * (ROOT_W - 1));
        end else if (r_busy) begin
            if (w_ge) begin
                r_x <= r_x - w_t;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/vn_div.sv
// ----------------------------------------------------------------------------
// vn_div
// Restoring divider: (mag << FRAC_BITS) / den for mag <= den, one quotient
// bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_div #(
    parameter int MAG_W = 24,
    parameter int DEN_W = 27
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [MAG_W-1:0]          i_mag,
    input  wire  [DEN_W-1:0]          i_den,
    output logic                      o_done,
    output logic [vn_pkg::QUOT_W-1:0] o_quot
);

    localparam int QW    = vn_pkg::QUOT_W;
    localparam int CNT_W = $clog2(QW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [QW-1:0]    r_quot;
    logic [DEN_W:0]   w_den;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;

    assign w_den  = {1'b0, i_den};
    assign w_ge   = (r_rem >= w_den);
    assign w_diff = w_ge ? (r_rem - w_den) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= (DEN_W + 1)'(i_mag);
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {w_diff[DEN_W-1:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> hw/rtl/vector_normalizer_unit.sv
// ----------------------------------------------------------------------------
// vector_normalizer_unit
// Euclidean vector normaliser: buffers one vector of Q8.16 samples, takes
// the floor square root of the sum of squares and emits each sample divided
// by that length as a Q1.30 unit component.
//
// Input stream (s_axis): one sample per transaction, tlast on the final one.
// Samples are taken one per cycle while the vector loads; tready drops after
// the tlast transaction until the last result has entered the output
// register. Samples beyond MAX_LEN are dropped and flag every result.
// Output stream (m_axis): one result per stored sample, tlast on the final
// one; tuser carries the zero-length and truncation flags.
// After the tlast transaction the squaring pipeline drains and the bit-serial
// root is started; then for each result the store is read, the divider is
// started, the 31-bit serial divider runs and the output register is loaded.
// When the length is zero the divider is skipped. The divider sets the rate.
// A stalled receiver holds the output register; the finished quotient waits
// in the divider and the next division starts once the register frees.
// Reset (synchronous, active low) empties the vector and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_normalizer_unit #(
    parameter int MAX_LEN     = vn_pkg::MAX_LEN,
    parameter int SAMPLE_BITS = vn_pkg::SAMPLE_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [23:0] element_value
    input  wire  [vn_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire                              s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [31:0] unit_value
    output logic [vn_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] zero_norm, [1] truncated
    output logic [vn_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int SUM_W  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_LEN);
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int OW     = vn_pkg::OUT_DATA_W;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_FLUSH = 7'b0000010,
        S_ROOT  = 7'b0000100,
        S_RD    = 7'b0001000,
        S_START = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_PUSH  = 7'b1000000
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic                      r_ovf, n_ovf;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [SAMPLE_BITS-1:0]    r_mag;
    logic                      r_mag_vld;
    logic [2*SAMPLE_BITS-1:0]  r_prod;
    logic                      r_prod_vld;
    logic [ROOT_W-1:0]         r_len;
    logic                      r_zero;
    logic                      r_neg;
    logic                      r_out_valid;
    logic [OW-1:0]             r_out_data;
    logic                      r_out_zero;
    logic                      r_out_trunc;
    logic                      r_out_last;

    logic [SAMPLE_BITS-1:0]    w_sample;
    logic [SAMPLE_BITS-1:0]    w_in_mag;
    logic                      w_accept;
    logic                      w_store;
    logic                      w_root_start;
    logic                      w_root_done;
    logic [ROOT_W-1:0]         w_root;
    logic                      w_rd_en;
    logic [SAMPLE_BITS-1:0]    w_rd_data;
    logic [SAMPLE_BITS-1:0]    w_rd_mag;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [vn_pkg::QUOT_W-1:0] w_quot;
    logic                      w_out_free;
    logic                      w_push;
    logic                      w_last;
    logic [OW-1:0]             w_unit_pos;
    logic [OW-1:0]             w_unit;

    assign w_sample   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_in_mag   = w_sample[SAMPLE_BITS-1] ? (~w_sample + 1'b1) : w_sample;
    assign w_rd_mag   = w_rd_data[SAMPLE_BITS-1] ? (~w_rd_data + 1'b1) : w_rd_data;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_store    = w_accept && (r_count != CNT_W'(MAX_LEN));
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_last     = (CNT_W'(r_idx + 1'b1) == r_count);
    assign w_unit_pos = OW'(w_quot);
    assign w_unit     = r_zero ? '0 : (r_neg ? (~w_unit_pos + 1'b1) : w_unit_pos);

    assign s_axis_tready = (r_state == S_LOAD);

    vn_store #(
        .DEPTH  (MAX_LEN),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (w_sample),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    vn_sqrt #(
        .SUM_W  (SUM_W),
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_x     (r_sum),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    vn_div #(
        .MAG_W (SAMPLE_BITS),
        .DEN_W (ROOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (w_rd_mag),
        .i_den   (r_len),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_ovf        = r_ovf;
        n_sum        = r_sum;
        w_root_start = 1'b0;
        w_rd_en      = 1'b0;
        w_div_start  = 1'b0;
        w_push       = 1'b0;
        if (w_accept) begin
            if (w_store) begin
                n_count = r_count + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (r_prod_vld) begin
            n_sum = r_sum + SUM_W'(r_prod);
        end
        case (r_state)
            S_LOAD: begin
                if (w_accept && s_axis_tlast) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_mag_vld && !r_prod_vld) begin
                    w_root_start = 1'b1;
                    n_state      = S_ROOT;
                end
            end
            S_ROOT: begin
                if (w_root_done) begin
                    n_idx   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_START;
            end
            S_START: begin
                if (r_zero) begin
                    n_state = S_PUSH;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    w_push = 1'b1;
                    if (w_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_sum   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_sum       <= '0;
            r_mag_vld   <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_ovf      <= n_ovf;
            r_sum      <= n_sum;
            r_mag_vld  <= w_store;
            r_prod_vld <= r_mag_vld;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= w_in_mag;
        r_prod <= r_mag * r_mag;
        if (w_root_done) begin
            r_len  <= w_root;
            r_zero <= (w_root == '0);
        end
        if (r_state == S_START) begin
            r_neg <= w_rd_data[SAMPLE_BITS-1];
        end
        if (w_push) begin
            r_out_data  <= w_unit;
            r_out_zero  <= r_zero;
            r_out_trunc <= r_ovf;
            r_out_last  <= w_last;
        end
    end

    assign m_axis_tvalid                    = r_out_valid;
    assign m_axis_tdata                     = r_out_data;
    assign m_axis_tuser[vn_pkg::USER_ZERO]  = r_out_zero;
    assign m_axis_tuser[vn_pkg::USER_TRUNC] = r_out_trunc;
    assign m_axis_tlast                     = r_out_last;

endmodule

`default_nettype wire

>>> hw/rtl/vn_checker.sv
// ----------------------------------------------------------------------------
// vn_checker
// Port-level checks on the vector normaliser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           s_axis_tvalid,
    input wire                           s_axis_tready,
    input wire                           s_axis_tlast,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [vn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire [vn_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    localparam int OW = vn_pkg::OUT_DATA_W;

    logic [OW-1:0] w_pos_one;

    assign w_pos_one = OW'(1) << vn_pkg::FRAC_BITS;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_zero_norm_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[vn_pkg::USER_ZERO] |-> m_axis_tdata == '0)
        else $error("zero-length vector with non-zero component");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OW-1] == m_axis_tdata[OW-2])
                          || (m_axis_tdata == w_pos_one))
        else $error("unit component out of range");

    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken while vector is being normalised");

endmodule

bind vector_normalizer_unit vn_checker u_vn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> dv/vector_normalizer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_normalizer_unit_tb
// Self-checking bench for the Euclidean vector normaliser. A short table of
// vectors covers the sample extremes, a zero vector and single-sample
// vectors with known answers. Random vectors follow, mostly short, some
// filling or overrunning the buffer, some all zero. Both stream sides idle at
// random. An in-bench predictor keeps its own sample buffer and sum of
// squares, and each output transaction is compared with the oldest
// predicted unit component.
// ----------------------------------------------------------------------------
module vector_normalizer_unit_tb;

    typedef struct packed {
        logic [vn_pkg::IN_DATA_W-1:0]  value;
        logic                          last;
        logic                          pinned;
        logic [vn_pkg::OUT_DATA_W-1:0] pin_unit;
        logic                          pin_zero;
    } t_stim_row;

    typedef struct {
        bit [vn_pkg::OUT_DATA_W-1:0] unit;
        bit                          zero;
        bit                          trunc;
        bit                          last;
    } t_unit_comp;

    localparam int N_ROWS = 18;

    // pinned rows give the unit component of every result of their vector
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{24'h010000, 1'b1, 1'b1, 32'h4000_0000, 1'b0},
        '{24'h800000, 1'b1, 1'b1, 32'hC000_0000, 1'b0},
        '{24'h7FFFFF, 1'b1, 1'b1, 32'h4000_0000, 1'b0},
        '{24'h000001, 1'b1, 1'b1, 32'h4000_0000, 1'b0},
        '{24'h000000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h000000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h000000, 1'b1, 1'b1, 32'h0,         1'b1},
        '{24'h030000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h040000, 1'b1, 1'b0, 32'h0,         1'b0},
        '{24'hFFFFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h000001, 1'b1, 1'b0, 32'h0,         1'b0},
        '{24'h7FFFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h800000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h000000, 1'b1, 1'b0, 32'h0,         1'b0},
        '{24'hFFFFFF, 1'b1, 1'b1, 32'hC000_0000, 1'b0},
        '{24'h555555, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'hAAAAAA, 1'b0, 1'b0, 32'h0,         1'b0},
        '{24'h123456, 1'b1, 1'b0, 32'h0,         1'b0}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [vn_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // [23:0] element_value
    logic                          s_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [vn_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] unit_value
    logic [vn_pkg::OUT_USER_W-1:0] m_axis_tuser;   // [0] zero_norm, [1] truncated
    logic                          m_axis_tlast;

    bit [vn_pkg::IN_DATA_W-1:0] sample_buf [vn_pkg::MAX_LEN];
    bit [52:0]                  sq_sum;
    int                         sample_cnt;
    bit                         overrun;
    t_unit_comp                 pending_units [$];

    int err_cnt, vec_cnt, sample_total, unit_cnt, overrun_vecs, zero_vecs;
    bit calm;

    vector_normalizer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit [63:0] sample_mag(bit [vn_pkg::IN_DATA_W-1:0] raw);
        bit [vn_pkg::IN_DATA_W-1:0] neg_raw;
        neg_raw = ~raw + 1'b1;
        return raw[vn_pkg::IN_DATA_W-1] ? 64'(neg_raw) : 64'(raw);
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] x);
        bit [63:0] root, trial;
        root = '0;
        for (int b = 27; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (calm || r < 8) return 0;
        if (r < 14) return $urandom_range(1, 3);
        if (r == 14) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [vn_pkg::IN_DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            2: return vn_pkg::IN_DATA_W'(int'($urandom_range(0, 510)) - 255);
            default: return vn_pkg::IN_DATA_W'($urandom);
        endcase
    endfunction

    // advance the normaliser state by one sample; on tlast queue the vector
    function automatic void take_sample(t_stim_row row);
        bit [63:0]  mag, len, quot;
        t_unit_comp comp;
        if (sample_cnt < vn_pkg::MAX_LEN) begin
            sample_buf[sample_cnt] = row.value;
            mag = sample_mag(row.value);
            sq_sum = sq_sum + 53'(mag * mag);
            sample_cnt++;
        end else begin
            overrun = 1'b1;
        end
        sample_total++;
        if (!row.last) return;
        len = floor_sqrt(64'(sq_sum));
        for (int k = 0; k < sample_cnt; k++) begin
            quot = (len == 0) ? 64'd0
                 : (sample_mag(sample_buf[k]) << vn_pkg::FRAC_BITS) / len;
            comp.unit  = sample_buf[k][vn_pkg::IN_DATA_W-1] ? 32'(-quot) : 32'(quot);
            comp.zero  = (len == 0);
            comp.trunc = overrun;
            comp.last  = (k == sample_cnt - 1);
            if (row.pinned) begin
                comp.unit = row.pin_unit;
                comp.zero = row.pin_zero;
            end
            pending_units.push_back(comp);
        end
        vec_cnt++;
        if (overrun) overrun_vecs++;
        if (len == 0) zero_vecs++;
        sq_sum     = '0;
        sample_cnt = 0;
        overrun    = 1'b0;
    endfunction

    task automatic send_sample(t_stim_row row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.value;
        s_axis_tlast  <= row.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        take_sample(row);
    endtask

    function automatic void check_field(string name, bit [31:0] want, bit [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            err_cnt++;
        end
    endfunction

    initial begin
        t_unit_comp want;
        int         stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_units.size() == 0) begin
                    $error("unexpected transaction: unit_value %h", m_axis_tdata);
                    err_cnt++;
                end else begin
                    want = pending_units.pop_front();
                    unit_cnt++;
                    check_field("unit_value", want.unit, m_axis_tdata);
                    check_field("zero_norm", 32'(want.zero),
                                32'(m_axis_tuser[vn_pkg::USER_ZERO]));
                    check_field("truncated", 32'(want.trunc),
                                32'(m_axis_tuser[vn_pkg::USER_TRUNC]));
                    check_field("result_last", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                stall = pick_gap();
                m_axis_tready <= (stall == 0);
            end
        end
    end

    initial begin
        t_stim_row row;
        int        vec_len, rand_cnt;
        bit        zero_vec;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        calm          = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) send_sample(DIRECTED_ROWS[i]);

        // first random vector overruns the buffer and drops its tlast sample
        rand_cnt = 0;
        while (rand_cnt < 82) begin
            if (rand_cnt == 0) begin
                vec_len = vn_pkg::MAX_LEN + 2;
            end else if ($urandom_range(0, 15) == 0) begin
                vec_len = $urandom_range(vn_pkg::MAX_LEN - 4, vn_pkg::MAX_LEN + 4);
            end else begin
                vec_len = $urandom_range(1, 8);
            end
            zero_vec = ($urandom_range(0, 9) == 0);
            calm     = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < vec_len; i++) begin
                row        = '0;
                row.value  = zero_vec ? '0 : rand_sample();
                row.last   = (i == vec_len - 1);
                send_sample(row);
                rand_cnt++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_units.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d vectors from %0d samples, %0d unit components checked",
                 vec_cnt, sample_total, unit_cnt);
        $display("Of these %0d vectors overran the buffer and %0d had zero length",
                 overrun_vecs, zero_vecs);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
